### src/lsa_pkg.sv
package lsa_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int ID_W      = 32;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 3;

  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  typedef enum logic [1:0] {
    SLOT_VACANT  = 2'd0,
    SLOT_CONFIG  = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e       status;
    logic [ID_W-1:0]   loaded_id;
    logic [TIME_W-1:0] last_use;
    logic              failed;
    logic [ID_W-1:0]   pending_id;
  } lsa_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic              we_status;
    slot_state_e       status;
    logic              we_loaded;
    logic [ID_W-1:0]   loaded_id;
    logic              we_stamp;
    logic [TIME_W-1:0] stamp;
    logic              we_failed;
    logic              failed;
    logic              we_pending;
    logic [ID_W-1:0]   pending_id;
  } lsa_wr_t;

  typedef struct packed {
    logic clear;
    logic step;
  } lsa_scan_ctl_t;

  typedef struct packed {
    logic              hit_found;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_found;
    logic [SLOT_W-1:0] lru_idx;
  } lsa_scan_res_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(cfg) > NUM_SLOTS) begin
      n = CNT_W'(NUM_SLOTS);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

### src/lsa_slot_table.sv
module lsa_slot_table
  import lsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output lsa_entry_t        rd_entry_o,
  input  lsa_wr_t           wr_i
);

  slot_state_e       status_q  [NUM_SLOTS];
  logic [ID_W-1:0]   loaded_q  [NUM_SLOTS];
  logic [TIME_W-1:0] last_q    [NUM_SLOTS];
  logic              failed_q  [NUM_SLOTS];
  logic [ID_W-1:0]   pending_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_q[i]  <= SLOT_VACANT;
        loaded_q[i]  <= '0;
        last_q[i]    <= '0;
        failed_q[i]  <= 1'b0;
        pending_q[i] <= '0;
      end
    end else begin
      if (wr_i.we_status)  status_q[wr_i.idx]  <= wr_i.status;
      if (wr_i.we_loaded)  loaded_q[wr_i.idx]  <= wr_i.loaded_id;
      if (wr_i.we_stamp)   last_q[wr_i.idx]    <= wr_i.stamp;
      if (wr_i.we_failed)  failed_q[wr_i.idx]  <= wr_i.failed;
      if (wr_i.we_pending) pending_q[wr_i.idx] <= wr_i.pending_id;
    end
  end

  always_comb begin
    rd_entry_o.status     = status_q[rd_idx_i];
    rd_entry_o.loaded_id  = loaded_q[rd_idx_i];
    rd_entry_o.last_use   = last_q[rd_idx_i];
    rd_entry_o.failed     = failed_q[rd_idx_i];
    rd_entry_o.pending_id = pending_q[rd_idx_i];
  end

endmodule

### src/lsa_scan_unit.sv
module lsa_scan_unit
  import lsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsa_scan_ctl_t     ctl_i,
  input  lsa_entry_t        entry_i,
  input  logic [SLOT_W-1:0] idx_i,
  input  logic [ID_W-1:0]   kid_i,
  output lsa_scan_res_t     res_o
);

  logic              hit_found_q;
  logic [SLOT_W-1:0] hit_idx_q;
  logic              free_found_q;
  logic [SLOT_W-1:0] lru_idx_q;
  logic [TIME_W-1:0] lru_time_q;

  logic is_free;
  logic is_hit;
  logic older;

  assign is_free = (entry_i.status == SLOT_VACANT);
  assign is_hit  = is_free && (entry_i.loaded_id == kid_i);
  assign older   = !free_found_q || (entry_i.last_use < lru_time_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (ctl_i.step) begin
      if (is_hit && !hit_found_q) hit_found_q <= 1'b1;
      if (is_free) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && !ctl_i.clear) begin
      if (is_hit && !hit_found_q) hit_idx_q <= idx_i;
      if (is_free && older) begin
        lru_idx_q  <= idx_i;
        lru_time_q <= entry_i.last_use;
      end
    end
  end

  assign res_o.hit_found  = hit_found_q;
  assign res_o.hit_idx    = hit_idx_q;
  assign res_o.free_found = free_found_q;
  assign res_o.lru_idx    = lru_idx_q;

endmodule

### src/lru_slot_allocator_with_affinity_top.sv
// Slot allocator for up to NUM_SLOTS reconfigurable accelerator slots, of which the first
// slots_in_use (clamped to 1..NUM_SLOTS) take part. A request walks the present slots one
// per cycle through a single shared compare unit, which tracks the first free slot already
// holding the kernel id and the free slot with the oldest stamp; a request passes through
// accept, one scan step per present slot, and commit. A load outcome or a completion
// reads its slot once and commits. in_stall_o is high while an item is at work; the
// result sits in an output register, so the next item may be accepted while it waits,
// and a commit holds only while a previous result is still stalled.
module lru_slot_allocator_with_affinity_top
  import lsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [ID_W-1:0]   kernel_id_i,
  input  logic [1:0]        slot_sel_i,
  input  logic              load_ok_i,
  input  logic [TIME_W-1:0] time_now_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [1:0]        slot_out_o,
  output logic              need_reload_o,
  output logic              whole_image_o,
  output logic              run_on_hw_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REQ_END,
    S_EVENT
  } state_e;

  state_e            state_q;
  logic [CFG_W-1:0]  slots_in_use_q;
  logic [SLOT_W-1:0] idx_q;
  logic [1:0]        cmd_q;
  logic [ID_W-1:0]   kid_q;
  logic [1:0]        sel_q;
  logic              ok_q;
  logic [TIME_W-1:0] now_q;

  logic              out_valid_q;
  logic              out_valid_d;
  logic [1:0]        status_q;
  logic [1:0]        slot_out_q;
  logic              need_reload_q;
  logic              whole_image_q;
  logic              run_on_hw_q;

  logic [CNT_W-1:0]  n;
  logic              in_fire;
  logic              can_emit;
  logic              emit;
  logic              last_idx;
  logic              sel_ok;
  logic [SLOT_W-1:0] rd_idx;
  lsa_entry_t        entry;
  lsa_wr_t           wr;
  lsa_scan_ctl_t     scan_ctl;
  lsa_scan_res_t     scan_res;

  logic [1:0]        res_status;
  logic [1:0]        res_slot;
  logic              res_reload;
  logic              res_whole;
  logic              res_hw;
  logic [SLOT_W-1:0] pick;

  assign n           = clamp_count(slots_in_use_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign emit        = (state_q == S_REQ_END || state_q == S_EVENT) && can_emit;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);
  assign last_idx    = (CNT_W'(idx_q) == n - CNT_W'(1));
  assign sel_ok      = (32'(sel_q) < 32'(n));
  assign rd_idx      = (state_q == S_SCAN) ? idx_q : SLOT_W'(sel_q);
  assign pick        = scan_res.hit_found ? scan_res.hit_idx : scan_res.lru_idx;

  assign scan_ctl.clear = in_fire;
  assign scan_ctl.step  = (state_q == S_SCAN);

  lsa_slot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (entry),
    .wr_i       (wr)
  );

  lsa_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .entry_i (entry),
    .idx_i   (idx_q),
    .kid_i   (kid_q),
    .res_o   (scan_res)
  );

  always_comb begin
    wr         = '0;
    wr.status  = SLOT_VACANT;
    res_status = STAT_INVALID;
    res_slot   = sel_q;
    res_reload = 1'b0;
    res_whole  = 1'b0;
    res_hw     = 1'b0;
    unique case (state_q)
      S_REQ_END: begin
        if (!scan_res.free_found) begin
          res_status = STAT_NO_FREE;
          res_slot   = 2'd0;
        end else begin
          res_status = STAT_DONE;
          res_slot   = 2'(pick);
          wr.idx       = pick;
          wr.we_status = can_emit;
          if (scan_res.hit_found) begin
            wr.status    = SLOT_RUNNING;
            wr.we_failed = can_emit;
            wr.failed    = 1'b0;
            res_hw       = 1'b1;
          end else begin
            wr.status     = SLOT_CONFIG;
            wr.we_pending = can_emit;
            wr.pending_id = kid_q;
            res_reload    = 1'b1;
            res_whole     = (n == CNT_W'(1));
          end
        end
      end
      S_EVENT: begin
        wr.idx = SLOT_W'(sel_q);
        if (cmd_q == CMD_LOAD && sel_ok && entry.status == SLOT_CONFIG) begin
          res_status   = STAT_DONE;
          res_hw       = ok_q;
          wr.we_status = can_emit;
          wr.status    = SLOT_RUNNING;
          wr.we_failed = can_emit;
          wr.failed    = !ok_q;
          wr.we_loaded = can_emit && ok_q;
          wr.loaded_id = entry.pending_id;
        end else if (cmd_q == CMD_FINISH && sel_ok && entry.status == SLOT_RUNNING) begin
          res_status   = STAT_DONE;
          res_hw       = !entry.failed;
          wr.we_status = can_emit;
          wr.status    = SLOT_VACANT;
          wr.we_stamp  = can_emit;
          wr.stamp     = now_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slots_in_use_q <= CFG_W'(1);
      idx_q          <= '0;
      out_valid_q    <= 1'b0;
      status_q       <= '0;
      slot_out_q     <= '0;
      need_reload_q  <= 1'b0;
      whole_image_q  <= 1'b0;
      run_on_hw_q    <= 1'b0;
    end else begin
      if (cfg_we_i) slots_in_use_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q   <= '0;
            state_q <= (cmd_i == CMD_REQUEST) ? S_SCAN : S_EVENT;
          end
        end
        S_SCAN: begin
          if (last_idx) begin
            state_q <= S_REQ_END;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        S_REQ_END, S_EVENT: begin
          if (can_emit) begin
            status_q      <= res_status;
            slot_out_q    <= res_slot;
            need_reload_q <= res_reload;
            whole_image_q <= res_whole;
            run_on_hw_q   <= res_hw;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      kid_q <= kernel_id_i;
      sel_q <= slot_sel_i;
      ok_q  <= load_ok_i;
      now_q <= time_now_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_out_o    = slot_out_q;
  assign need_reload_o = need_reload_q;
  assign whole_image_o = whole_image_q;
  assign run_on_hw_o   = run_on_hw_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CNT_W'(idx_q) < n)
    else $error("scan index beyond slot count");

  a_no_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_NO_FREE |->
      slot_out_o == 2'd0 && !need_reload_o && !whole_image_o && !run_on_hw_o)
    else $error("refused request carries nonzero fields");

  a_whole_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && whole_image_o |-> need_reload_o && !run_on_hw_o)
    else $error("whole image without reload");

  a_hit_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REQ_END && scan_res.hit_found |-> scan_res.free_found)
    else $error("affinity hit on a slot that was not free");

endmodule

### sim/testbench.sv
module testbench;
  import lsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 127;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] slot;
    logic       reload;
    logic       whole;
    logic       hw;
  } slot_reply_t;

  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_PRED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        cmd;
    logic [ID_W-1:0]   kid;
    logic [1:0]        sel;
    logic              ok;
    logic [TIME_W-1:0] now;
    logic [CFG_W-1:0]  cfg_value;
    slot_reply_t       reply;
  } dir_row_t;

  localparam slot_reply_t NO_REPLY = '0;

  localparam dir_row_t DIR_ROWS [27] = '{
    '{ROW_TYPED, CMD_REQUEST, 32'h0, 2'd0, 1'b0, 32'h0, 3'd0,
      '{STAT_DONE, 2'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_TYPED, CMD_REQUEST, 32'd5, 2'd0, 1'b1, 32'h0, 3'd0,
      '{STAT_NO_FREE, 2'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_LOAD, 32'h0, 2'd0, 1'b1, 32'h0, 3'd0,
      '{STAT_INVALID, 2'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_FINISH, 32'h0, 2'd1, 1'b0, 32'h0, 3'd0,
      '{STAT_INVALID, 2'd1, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_UNUSED, 32'hFFFFFFFF, 2'd3, 1'b1, 32'hFFFFFFFF, 3'd0,
      '{STAT_INVALID, 2'd3, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_FINISH, 32'h0, 2'd0, 1'b0, 32'hFFFFFFFF, 3'd0,
      '{STAT_DONE, 2'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_TYPED, CMD_REQUEST, 32'hFFFFFFFF, 2'd0, 1'b0, 32'h0, 3'd0,
      '{STAT_DONE, 2'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_TYPED, CMD_REQUEST, 32'd7, 2'd0, 1'b0, 32'h0, 3'd0,
      '{STAT_NO_FREE, 2'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_LOAD, 32'h0, 2'd0, 1'b0, 32'h0, 3'd0,
      '{STAT_DONE, 2'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_FINISH, 32'h0, 2'd0, 1'b0, 32'h0, 3'd0,
      '{STAT_DONE, 2'd0, 1'b0, 1'b0, 1'b0}},
    // failed load keeps the old id, so this hits
    '{ROW_PRED, CMD_REQUEST, 32'h0, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_FINISH, 32'h0, 2'd0, 1'b0, 32'd100, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_REQUEST, 32'hFFFFFFFF, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_LOAD, 32'h0, 2'd0, 1'b1, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_FINISH, 32'h0, 2'd0, 1'b0, 32'd50, 3'd0, NO_REPLY},
    '{ROW_CFG, CMD_REQUEST, 32'h0, 2'd0, 1'b0, 32'h0, 3'd4, NO_REPLY},
    '{ROW_PRED, CMD_REQUEST, 32'hFFFFFFFF, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    // equal stamps: lowest free slot wins
    '{ROW_PRED, CMD_REQUEST, 32'hA5A5A5A5, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_REQUEST, 32'h5A5A5A5A, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_REQUEST, 32'd1, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_REQUEST, 32'd2, 2'd0, 1'b0, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_LOAD, 32'h0, 2'd3, 1'b1, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_FINISH, 32'h0, 2'd3, 1'b0, 32'hFFFFFFFF, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_LOAD, 32'h0, 2'd1, 1'b1, 32'h0, 3'd0, NO_REPLY},
    '{ROW_CFG, CMD_REQUEST, 32'h0, 2'd0, 1'b0, 32'h0, 3'd2, NO_REPLY},
    // slot 2 is still configuring but hidden by the smaller count
    '{ROW_PRED, CMD_LOAD, 32'h0, 2'd2, 1'b1, 32'h0, 3'd0, NO_REPLY},
    '{ROW_PRED, CMD_FINISH, 32'h0, 2'd1, 1'b0, 32'd20, 3'd0, NO_REPLY}
  };

  localparam logic [CFG_W-1:0] PHASE_CFG [12] = '{
    3'd4, 3'd4, 3'd2, 3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        cmd_i;
  logic [ID_W-1:0]   kernel_id_i;
  logic [1:0]        slot_sel_i;
  logic              load_ok_i;
  logic [TIME_W-1:0] time_now_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [1:0]        slot_out_o;
  logic              need_reload_o;
  logic              whole_image_o;
  logic              run_on_hw_o;

  slot_state_e       slot_st [NUM_SLOTS];
  logic [ID_W-1:0]   slot_id [NUM_SLOTS];
  logic [ID_W-1:0]   slot_pend [NUM_SLOTS];
  logic [TIME_W-1:0] slot_stamp [NUM_SLOTS];
  logic              slot_failed [NUM_SLOTS];
  logic [CFG_W-1:0]  slots_cfg;

  slot_reply_t       slot_replies_q [$];
  logic              typed_check;
  slot_reply_t       typed_reply;
  logic [ID_W-1:0]   kid_pool [6];
  logic [TIME_W-1:0] uptime;
  bit                gaps_on;
  bit                stall_on;
  int                hold_reqs;
  int                fail_count;
  int                n_hit, n_reload, n_refused, n_load, n_finish, n_invalid;

  lru_slot_allocator_with_affinity_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .kernel_id_i  (kernel_id_i),
    .slot_sel_i   (slot_sel_i),
    .load_ok_i    (load_ok_i),
    .time_now_i   (time_now_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_out_o   (slot_out_o),
    .need_reload_o(need_reload_o),
    .whole_image_o(whole_image_o),
    .run_on_hw_o  (run_on_hw_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int present_slots();
    int n;
    n = int'(slots_cfg);
    if (n < 1) n = 1;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    return n;
  endfunction

  function automatic slot_reply_t track_slot_event(input logic [1:0] c,
                                                   input logic [ID_W-1:0] kid,
                                                   input logic [1:0] sel,
                                                   input logic ok,
                                                   input logic [TIME_W-1:0] now);
    slot_reply_t r;
    int n;
    int i;
    int pick;
    bit found;
    r = '0;
    n = present_slots();
    pick = 0;
    found = 1'b0;
    if (c == CMD_REQUEST) begin
      for (i = 0; i < n; i++) begin
        if (!found && slot_st[i] == SLOT_VACANT && slot_id[i] == kid) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        for (i = 0; i < n; i++) begin
          if (slot_st[i] == SLOT_VACANT && (!found || slot_stamp[i] < slot_stamp[pick])) begin
            pick = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        r.status = STAT_NO_FREE;
        n_refused++;
      end else if (slot_id[pick] != kid) begin
        slot_st[pick] = SLOT_CONFIG;
        slot_pend[pick] = kid;
        r = '{STAT_DONE, 2'(pick), 1'b1, (n == 1), 1'b0};
        n_reload++;
      end else begin
        slot_st[pick] = SLOT_RUNNING;
        slot_failed[pick] = 1'b0;
        r = '{STAT_DONE, 2'(pick), 1'b0, 1'b0, 1'b1};
        n_hit++;
      end
    end else if (c == CMD_LOAD && int'(sel) < n && slot_st[sel] == SLOT_CONFIG) begin
      if (ok) begin
        slot_id[sel] = slot_pend[sel];
        slot_failed[sel] = 1'b0;
      end else begin
        slot_failed[sel] = 1'b1;
      end
      slot_st[sel] = SLOT_RUNNING;
      r = '{STAT_DONE, sel, 1'b0, 1'b0, ok};
      n_load++;
    end else if (c == CMD_FINISH && int'(sel) < n && slot_st[sel] == SLOT_RUNNING) begin
      r = '{STAT_DONE, sel, 1'b0, 1'b0, !slot_failed[sel]};
      slot_st[sel] = SLOT_VACANT;
      slot_stamp[sel] = now;
      n_finish++;
    end else begin
      r.status = STAT_INVALID;
      r.slot = sel;
      n_invalid++;
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [TIME_W-1:0] next_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return uptime;
    uptime = uptime + $urandom_range(1, 25);
    return uptime;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    slot_reply_t want;
    slot_reply_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = track_slot_event(cmd_i, kernel_id_i, slot_sel_i, load_ok_i, time_now_i);
        if (typed_check) want = typed_reply;
        slot_replies_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, slot_out_o, need_reload_o, whole_image_o, run_on_hw_o};
        if (slot_replies_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected item status=%0d slot=%0d reload=%b whole=%b hw=%b",
                     $realtime, got.status, got.slot, got.reload, got.whole, got.hw);
          fail_count++;
        end else begin
          want = slot_replies_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"%0t: item mismatch exp status=%0d slot=%0d reload=%b whole=%b hw=%b",
                        " got status=%0d slot=%0d reload=%b whole=%b hw=%b"},
                       $realtime, want.status, want.slot, want.reload, want.whole, want.hw,
                       got.status, got.slot, got.reload, got.whole, got.hw);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat (gap_len()) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_event(input logic [1:0] c, input logic [ID_W-1:0] kid,
                            input logic [1:0] sel, input logic ok,
                            input logic [TIME_W-1:0] now,
                            input logic typed, input slot_reply_t reply);
    in_valid_i = 1'b1;
    cmd_i = c;
    kernel_id_i = kid;
    slot_sel_i = sel;
    load_ok_i = ok;
    time_now_i = now;
    typed_check = typed;
    typed_reply = reply;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      // scramble the idle payload
      in_valid_i = 1'b0;
      cmd_i = 2'($urandom());
      kernel_id_i = $urandom();
      slot_sel_i = 2'($urandom());
      load_ok_i = 1'($urandom());
      time_now_i = $urandom();
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    in_valid_i = 1'b0;
    while (slot_replies_q.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    slots_cfg = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_random_event();
    int unsigned r;
    int n;
    int i;
    int busy_slots [$];
    logic [1:0] sel;
    r = $urandom_range(0, 99);
    n = present_slots();
    for (i = 0; i < n; i++)
      if (slot_st[i] != SLOT_VACANT) busy_slots.push_back(i);
    if (r >= 85) begin
      send_event(2'($urandom()), $urandom(), 2'($urandom()), 1'($urandom()), $urandom(),
                 1'b0, NO_REPLY);
    end else if (r >= 40 && busy_slots.size() != 0) begin
      sel = 2'(busy_slots[$urandom_range(0, busy_slots.size() - 1)]);
      if (slot_st[sel] == SLOT_CONFIG)
        send_event(CMD_LOAD, $urandom(), sel, ($urandom_range(0, 4) != 0), $urandom(),
                   1'b0, NO_REPLY);
      else
        send_event(CMD_FINISH, $urandom(), sel, 1'($urandom()), next_time(),
                   1'b0, NO_REPLY);
    end else begin
      send_event(CMD_REQUEST,
                 ($urandom_range(0, 3) != 0) ? kid_pool[$urandom_range(0, 5)] : $urandom(),
                 2'($urandom()), 1'($urandom()), $urandom(), 1'b0, NO_REPLY);
    end
  endtask

  initial begin : stimulus
    int i;
    int p;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_REQUEST;
    kernel_id_i = '0;
    slot_sel_i = '0;
    load_ok_i = 1'b0;
    time_now_i = '0;
    typed_check = 1'b0;
    typed_reply = NO_REPLY;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    hold_reqs = 0;
    fail_count = 0;
    uptime = '0;
    slots_cfg = 3'd1;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_st[i] = SLOT_VACANT;
      slot_id[i] = '0;
      slot_pend[i] = '0;
      slot_stamp[i] = '0;
      slot_failed[i] = 1'b0;
    end
    kid_pool[0] = '0;
    kid_pool[1] = '1;
    for (i = 2; i < 6; i++) kid_pool[i] = $urandom();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIR_ROWS[k]) begin
      if (DIR_ROWS[k].kind == ROW_CFG)
        write_slot_count(DIR_ROWS[k].cfg_value);
      else
        send_event(DIR_ROWS[k].cmd, DIR_ROWS[k].kid, DIR_ROWS[k].sel, DIR_ROWS[k].ok,
                   DIR_ROWS[k].now, (DIR_ROWS[k].kind == ROW_TYPED), DIR_ROWS[k].reply);
    end

    for (p = 0; p < 12; p++) begin
      write_slot_count(PHASE_CFG[p]);
      gaps_on = (p >= 2) && (p % 4 != 3);
      stall_on = (p >= 2) && (p % 4 != 2);
      // hold the output side while items keep coming
      if (p == 1) hold_reqs++;
      repeat (PHASE_ITEMS) send_random_event();
    end
    in_valid_i = 1'b0;

    while (slot_replies_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("covered %0d hits, %0d reloads, %0d refused requests, %0d load reports,",
             n_hit, n_reload, n_refused, n_load);
    $display("  %0d completions, %0d invalid events over slot counts 0..7, %0d mismatches",
             n_finish, n_invalid, fail_count);
    if (fail_count == 0) begin
      $display("lru_slot_allocator_with_affinity_top: match");
    end else begin
      $display("lru_slot_allocator_with_affinity_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("lru_slot_allocator_with_affinity_top: mismatch");
    $finish;
  end

endmodule

### sim.f
src/lsa_pkg.sv
src/lsa_slot_table.sv
src/lsa_scan_unit.sv
src/lru_slot_allocator_with_affinity_top.sv
sim/testbench.sv
